FILE: hw/rtl/hem_pkg.sv
// Shared types, codes and constants for the haptic envelope mixer.
`timescale 1ns / 1ps
package hem_pkg;

	localparam int SLOT_COUNT_DEF = 16;
	localparam int PORT_COUNT_DEF = 4;

	localparam int SPEED_MAX   = 65535;
	localparam int PERCENT_MAX = 100;

	// floor(x / 100) == (x * RECIP_MUL) >> RECIP_SHIFT for x < 2^23
	localparam int RECIP_SHIFT = 30;
	localparam logic [23:0] RECIP_MUL = 24'd10737419;

	localparam int CFG_OUTPUT_ENABLE = 0;
	localparam int CFG_DRIVE_ENABLE  = 1;

	typedef enum logic [1:0] {
		ACT_TICK  = 2'd0,
		ACT_ADD   = 2'd1,
		ACT_CLEAR = 2'd2,
		ACT_NONE  = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_ADD_WALK,
		ST_TICK_WALK,
		ST_EMIT
	} state_t;

	typedef enum logic {
		WALK_TICK,
		WALK_ADD
	} walk_mode_t;

	typedef struct packed {
		logic               valid;
		logic [1:0]         port;
		logic               motor;
		logic [15:0]        peak;
		logic signed [17:0] level;
		logic signed [17:0] step;
		logic [15:0]        hold;
		logic [15:0]        delay;
	} slot_t;

	// one slot's share of the per-port maximum
	typedef struct packed {
		logic        hit;
		logic [1:0]  port;
		logic        motor;
		logic [16:0] level;
	} contrib_t;

endpackage

FILE: hw/rtl/hem_cell.sv
// One envelope slot of the rotating slot ring.
`timescale 1ns / 1ps
module hem_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          shift,
	input  logic          clear,
	input  hem_pkg::slot_t din,
	output hem_pkg::slot_t dout
);
	import hem_pkg::*;

	logic  valid_q;
	slot_t pay_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (clear) begin
			valid_q <= 1'b0;
		end else if (shift) begin
			valid_q <= din.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			pay_q <= din;
		end
	end

	always_comb begin
		dout       = pay_q;
		dout.valid = valid_q;
	end

endmodule

FILE: hw/rtl/hem_update.sv
// Envelope step and slot insert applied to the slot leaving the ring head.
`timescale 1ns / 1ps
module hem_update (
	input  hem_pkg::walk_mode_t mode,
	input  logic                ins_en,
	input  hem_pkg::slot_t      new_slot,
	input  hem_pkg::slot_t      slot_in,
	output hem_pkg::slot_t      slot_out,
	output hem_pkg::contrib_t   contrib
);
	import hem_pkg::*;

	logic signed [17:0] step_eff;
	logic signed [18:0] next;
	logic               at_peak;

	always_comb begin
		slot_out      = slot_in;
		contrib.hit   = 1'b0;
		contrib.port  = slot_in.port;
		contrib.motor = slot_in.motor;
		contrib.level = '0;
		step_eff      = slot_in.step;
		next          = '0;
		at_peak       = slot_in.level >= $signed({2'b00, slot_in.peak});

		unique case (mode)
			WALK_ADD: begin
				// first free slot seen in the walk takes the new envelope
				if (ins_en && !slot_in.valid) begin
					slot_out = new_slot;
				end
			end
			WALK_TICK: begin
				if (slot_in.valid) begin
					if (slot_in.delay != 16'd0) begin
						slot_out.delay = slot_in.delay - 16'd1;
					end else begin
						if (at_peak && slot_in.hold != 16'd0) begin
							next          = 19'($signed({2'b00, slot_in.peak}));
							slot_out.hold = slot_in.hold - 16'd1;
						end else begin
							if (at_peak && slot_in.step > 18'sd0) begin
								step_eff = -slot_in.step;
							end
							next = 19'(slot_in.level) + 19'(step_eff);
						end
						slot_out.step = step_eff;
						if (next > 19'sd0) begin
							slot_out.level = 18'(next);
							contrib.hit    = 1'b1;
							contrib.level  = 17'(next);
						end else begin
							slot_out.valid = 1'b0;
						end
					end
				end
			end
		endcase
	end

endmodule

FILE: hw/rtl/haptic_envelope_mixer.sv
// Top level of the haptic envelope mixer: control, slot ring and speed output.
`timescale 1ns / 1ps
// Usage:
// The input channel (in_valid/in_ready) carries one action per transaction:
// tick, add envelope or clear. One transaction is worked at a time; in_ready
// is high only while the block is idle.
// A tick rotates the ring of SLOT_COUNT slot cells once, one slot through the
// envelope step unit per cycle, then sends PORT_COUNT results on the output
// channel (out_valid/out_ready), one per cycle when the receiver takes them;
// last marks the final port. An add computes the ramp step (multiply, then
// reciprocal divide), then walks the ring once and loads the first free slot;
// it sends nothing. A clear frees all slots and sends PORT_COUNT zero results.
// With drive_enable low, ticks and clears send nothing.
// A stalled receiver holds the block in the output phase with the result
// unchanged; no input is taken until the last result is taken.
// Reset frees every slot and sets output_enable and drive_enable to 1.
// Registers on the APB port: output_enable at 0x0, drive_enable at 0x4.
module haptic_envelope_mixer #(
	parameter int SLOT_COUNT = hem_pkg::SLOT_COUNT_DEF,
	parameter int PORT_COUNT = hem_pkg::PORT_COUNT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  action,
	input  logic [1:0]  target_port,
	input  logic        motor_select,
	input  logic [15:0] peak_speed,
	input  logic [15:0] start_speed,
	input  logic [6:0]  ramp_percent,
	input  logic [15:0] hold_ticks,
	input  logic [15:0] delay_ticks,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  out_port,
	output logic [15:0] left_speed,
	output logic [15:0] right_speed,
	output logic        last
);
	import hem_pkg::*;

	localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int PW = (PORT_COUNT > 1) ? $clog2(PORT_COUNT) : 1;
	localparam logic [SW-1:0] SLOT_LAST = SW'(SLOT_COUNT - 1);
	localparam logic [PW-1:0] PORT_LAST = PW'(PORT_COUNT - 1);

	state_t state_q, state_d;

	logic output_enable_q, drive_enable_q;
	logic cfg_wr;

	logic [SW-1:0] slot_cnt_q;
	logic [PW-1:0] port_cnt_q;
	logic          inserted_q;
	logic          zero_q;

	slot_t       new_q;
	logic [6:0]  pct_q;
	logic [22:0] prod_s1;
	logic [46:0] quot_full;

	logic [16:0] left_max_q  [PORT_COUNT];
	logic [16:0] right_max_q [PORT_COUNT];

	slot_t      ring [SLOT_COUNT];
	slot_t      upd_out;
	contrib_t   contrib;
	walk_mode_t mode;
	logic       shift, clear_cells, in_acc, out_acc, port_ok;
	action_t    act;

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign prdata = paddr[2] ? {31'd0, drive_enable_q} : {31'd0, output_enable_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			output_enable_q <= 1'b1;
			drive_enable_q  <= 1'b1;
		end else if (cfg_wr) begin
			if (32'(paddr[2]) == CFG_DRIVE_ENABLE) begin
				drive_enable_q <= pwdata[0];
			end else begin
				output_enable_q <= pwdata[0];
			end
		end
	end

	// slot ring: cell 0 is the head, its slot goes through the update unit
	// and re-enters at the tail
	genvar gi;
	generate
		for (gi = 0; gi < SLOT_COUNT; gi++) begin : g_cell
			slot_t din;
			if (gi == SLOT_COUNT - 1) begin : g_tail
				assign din = upd_out;
			end else begin : g_mid
				assign din = ring[gi + 1];
			end
			hem_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.shift  (shift),
				.clear  (clear_cells),
				.din    (din),
				.dout   (ring[gi])
			);
		end
	endgenerate

	hem_update u_update (
		.mode     (mode),
		.ins_en   (!inserted_q),
		.new_slot (new_q),
		.slot_in  (ring[0]),
		.slot_out (upd_out),
		.contrib  (contrib)
	);

	assign act     = action_t'(action);
	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;
	assign port_ok = 32'(target_port) < PORT_COUNT;
	assign quot_full = 47'(prod_s1) * 47'(RECIP_MUL);

	always_comb begin
		state_d     = state_q;
		in_ready    = 1'b0;
		out_valid   = 1'b0;
		shift       = 1'b0;
		clear_cells = 1'b0;
		mode        = WALK_TICK;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					unique case (act)
						ACT_TICK:  state_d = ST_TICK_WALK;
						ACT_ADD:   state_d = port_ok ? ST_MUL : ST_IDLE;
						ACT_CLEAR: begin
							clear_cells = 1'b1;
							state_d     = drive_enable_q ? ST_EMIT : ST_IDLE;
						end
						ACT_NONE:  state_d = ST_IDLE;
					endcase
				end
			end
			ST_MUL: state_d = ST_DIV;
			ST_DIV: state_d = ST_ADD_WALK;
			ST_ADD_WALK: begin
				shift = 1'b1;
				mode  = WALK_ADD;
				if (slot_cnt_q == SLOT_LAST) begin
					state_d = ST_IDLE;
				end
			end
			ST_TICK_WALK: begin
				shift = 1'b1;
				if (slot_cnt_q == SLOT_LAST) begin
					state_d = drive_enable_q ? ST_EMIT : ST_IDLE;
				end
			end
			ST_EMIT: begin
				out_valid = 1'b1;
				if (out_ready && port_cnt_q == PORT_LAST) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			slot_cnt_q <= '0;
			port_cnt_q <= '0;
			inserted_q <= 1'b0;
			zero_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_acc) begin
				slot_cnt_q <= '0;
				port_cnt_q <= '0;
				inserted_q <= 1'b0;
				zero_q     <= 1'b1;
			end else if (shift) begin
				slot_cnt_q <= slot_cnt_q + SW'(1);
				if (mode == WALK_ADD && !ring[0].valid) begin
					inserted_q <= 1'b1;
				end
				zero_q <= !output_enable_q;
			end else if (out_acc) begin
				port_cnt_q <= port_cnt_q + PW'(1);
			end
		end
	end

	// add: capture fields, then step = floor(peak * pct / 100)
	always_ff @(posedge clk) begin
		if (in_acc) begin
			new_q.valid <= 1'b1;
			new_q.port  <= target_port;
			new_q.motor <= motor_select;
			new_q.peak  <= peak_speed;
			new_q.level <= $signed({2'b00, start_speed});
			new_q.hold  <= hold_ticks;
			new_q.delay <= delay_ticks;
			pct_q       <= (32'(ramp_percent) > PERCENT_MAX) ? 7'(PERCENT_MAX) : ramp_percent;
		end
		if (state_q == ST_MUL) begin
			prod_s1 <= 23'(new_q.peak) * 23'(pct_q);
		end
		if (state_q == ST_DIV) begin
			new_q.step <= $signed({2'b00, quot_full[RECIP_SHIFT +: 16]});
		end
	end

	// per-port maxima over the tick walk
	always_ff @(posedge clk) begin
		for (int p = 0; p < PORT_COUNT; p++) begin
			if (in_acc) begin
				left_max_q[p]  <= '0;
				right_max_q[p] <= '0;
			end else if (shift && contrib.hit && int'(contrib.port) == p) begin
				if (!contrib.motor && contrib.level > left_max_q[p]) begin
					left_max_q[p] <= contrib.level;
				end
				if (contrib.motor && contrib.level > right_max_q[p]) begin
					right_max_q[p] <= contrib.level;
				end
			end
		end
	end

	logic [16:0] lsel, rsel;
	assign lsel = left_max_q[port_cnt_q];
	assign rsel = right_max_q[port_cnt_q];

	assign out_port    = 2'(port_cnt_q);
	assign last        = port_cnt_q == PORT_LAST;
	assign left_speed  = zero_q ? 16'd0 : (lsel[16] ? 16'(SPEED_MAX) : lsel[15:0]);
	assign right_speed = zero_q ? 16'd0 : (rsel[16] ? 16'(SPEED_MAX) : rsel[15:0]);

endmodule

FILE: dv/hem_checker.sv
// Scoreboard for the haptic envelope mixer: slot table predictor and result compare.
`timescale 1ns / 1ps
module hem_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [1:0]  action,
	input  logic [1:0]  target_port,
	input  logic        motor_select,
	input  logic [15:0] peak_speed,
	input  logic [15:0] start_speed,
	input  logic [6:0]  ramp_percent,
	input  logic [15:0] hold_ticks,
	input  logic [15:0] delay_ticks,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [1:0]  out_port,
	input  logic [15:0] left_speed,
	input  logic [15:0] right_speed,
	input  logic        last,
	input  logic        drain_check,
	output int          pending,
	output int          mismatches
);
	import hem_pkg::*;

	localparam int SLOTS     = SLOT_COUNT_DEF;
	localparam int PORTS     = PORT_COUNT_DEF;
	localparam int PRINT_CAP = 40;

	typedef struct packed {
		logic [1:0]  port;
		logic [15:0] left;
		logic [15:0] right;
		logic        last;
	} speed_row_t;

	speed_row_t speed_rows_q[$];

	logic output_en;
	logic drive_en;

	logic               env_valid [SLOTS];
	logic [1:0]         env_port  [SLOTS];
	logic               env_motor [SLOTS];
	logic [15:0]        env_peak  [SLOTS];
	logic signed [17:0] env_level [SLOTS];
	logic signed [17:0] env_step  [SLOTS];
	logic [15:0]        env_hold  [SLOTS];
	logic [15:0]        env_delay [SLOTS];

	int max_left  [PORTS];
	int max_right [PORTS];

	int mismatch_total = 0;
	assign mismatches = mismatch_total;

	task automatic report_mismatch(input string what);
		if (mismatch_total < PRINT_CAP)
			$display("%0t mismatch: %s", $time, what);
		mismatch_total++;
	endtask

	function automatic logic [15:0] clamp_speed(input int v);
		if (v <= 0)
			return 16'd0;
		if (v > SPEED_MAX)
			return 16'hFFFF;
		return v[15:0];
	endfunction

	task automatic push_rows(input bit zero);
		speed_row_t row;
		for (int p = 0; p < PORTS; p++) begin
			row.port  = 2'(p);
			row.left  = zero ? 16'd0 : clamp_speed(max_left[p]);
			row.right = zero ? 16'd0 : clamp_speed(max_right[p]);
			row.last  = (p == PORTS - 1);
			speed_rows_q.insert(speed_rows_q.size(), row);
		end
	endtask

	task automatic free_envelopes();
		for (int i = 0; i < SLOTS; i++)
			env_valid[i] = 1'b0;
	endtask

	task automatic load_envelope();
		int  pct;
		bit  placed;
		placed = 0;
		pct = (ramp_percent > PERCENT_MAX) ? PERCENT_MAX : int'(ramp_percent);
		if (int'(target_port) < PORTS) begin
			for (int i = 0; i < SLOTS; i++) begin
				if (!placed && !env_valid[i]) begin
					placed       = 1;
					env_valid[i] = 1'b1;
					env_port[i]  = target_port;
					env_motor[i] = motor_select;
					env_peak[i]  = peak_speed;
					env_level[i] = {2'b00, start_speed};
					env_step[i]  = 18'((int'(peak_speed) * pct) / 100);
					env_hold[i]  = hold_ticks;
					env_delay[i] = delay_ticks;
				end
			end
		end
	endtask

	task automatic tick_envelopes();
		int nxt;
		int lv;
		int pk;
		int st;
		for (int p = 0; p < PORTS; p++) begin
			max_left[p]  = 0;
			max_right[p] = 0;
		end
		for (int i = 0; i < SLOTS; i++) begin
			if (env_valid[i]) begin
				if (env_delay[i] != 0) begin
					env_delay[i] = env_delay[i] - 1'b1;
				end else begin
					lv = env_level[i];
					pk = env_peak[i];
					st = env_step[i];
					if (lv >= pk) begin
						if (env_hold[i] != 0) begin
							nxt = pk;
							env_hold[i] = env_hold[i] - 1'b1;
						end else begin
							// past hold: flip to release
							if (st > 0) begin
								st = -st;
								env_step[i] = st[17:0];
							end
							nxt = lv + st;
						end
					end else begin
						nxt = lv + st;
					end
					if (nxt > 0) begin
						if (env_motor[i] == 1'b0) begin
							if (nxt > max_left[env_port[i]])
								max_left[env_port[i]] = nxt;
						end else begin
							if (nxt > max_right[env_port[i]])
								max_right[env_port[i]] = nxt;
						end
						env_level[i] = nxt[17:0];
					end else begin
						env_valid[i] = 1'b0;
					end
				end
			end
		end
	endtask

	task automatic check_row();
		speed_row_t want;
		if (speed_rows_q.size() == 0) begin
			report_mismatch($sformatf("unexpected result port %0d left %0d right %0d last %0b",
				out_port, left_speed, right_speed, last));
		end else begin
			want = speed_rows_q.pop_front();
			if (out_port !== want.port)
				report_mismatch($sformatf("out_port got %0d want %0d", out_port, want.port));
			if (left_speed !== want.left)
				report_mismatch($sformatf("left_speed port %0d got %0d want %0d",
					want.port, left_speed, want.left));
			if (right_speed !== want.right)
				report_mismatch($sformatf("right_speed port %0d got %0d want %0d",
					want.port, right_speed, want.right));
			if (last !== want.last)
				report_mismatch($sformatf("last port %0d got %0b want %0b",
					want.port, last, want.last));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			output_en = 1'b1;
			drive_en  = 1'b1;
			free_envelopes();
			speed_rows_q.delete();
			pending = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (int'(paddr >> 2))
					CFG_OUTPUT_ENABLE: output_en = pwdata[0];
					CFG_DRIVE_ENABLE:  drive_en  = pwdata[0];
					default: ;
				endcase
			end
			if (out_valid && out_ready)
				check_row();
			if (in_valid && in_ready) begin
				case (action_t'(action))
					ACT_TICK: begin
						tick_envelopes();
						if (drive_en)
							push_rows(!output_en);
					end
					ACT_ADD: load_envelope();
					ACT_CLEAR: begin
						free_envelopes();
						if (drive_en)
							push_rows(1'b1);
					end
					default: ;
				endcase
			end
			pending = speed_rows_q.size();
		end
	end

	always @(posedge drain_check) begin
		if (speed_rows_q.size() != 0)
			report_mismatch($sformatf("%0d expected results never arrived", speed_rows_q.size()));
	end

endmodule

FILE: dv/tb.sv
// Top of the haptic envelope mixer testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb;
	import hem_pkg::*;

	localparam int RAND_SEGMENTS  = 6;
	localparam int RAND_PER_SEG   = 59;
	localparam int SETTLE_CYCLES  = 40;
	localparam int WATCHDOG_LIMIT = 3000;
	// per-segment register plan, bit n for segment n
	localparam bit [5:0] OE_PLAN = 6'b101010;
	localparam bit [5:0] DE_PLAN = 6'b111001;

	logic clk = 1'b0;
	logic arst_n;

	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	logic        in_valid;
	logic        in_ready;
	logic [1:0]  action;
	logic [1:0]  target_port;
	logic        motor_select;
	logic [15:0] peak_speed;
	logic [15:0] start_speed;
	logic [6:0]  ramp_percent;
	logic [15:0] hold_ticks;
	logic [15:0] delay_ticks;

	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  out_port;
	logic [15:0] left_speed;
	logic [15:0] right_speed;
	logic        last;

	logic drain_check;
	int   pending;
	int   mismatches;

	int in_idle_pct;
	int out_idle_pct;
	int txn_count;
	int quiet_cycles = 0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	haptic_envelope_mixer u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.action      (action),
		.target_port (target_port),
		.motor_select(motor_select),
		.peak_speed  (peak_speed),
		.start_speed (start_speed),
		.ramp_percent(ramp_percent),
		.hold_ticks  (hold_ticks),
		.delay_ticks (delay_ticks),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_port    (out_port),
		.left_speed  (left_speed),
		.right_speed (right_speed),
		.last        (last)
	);

	hem_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.pready      (pready),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.action      (action),
		.target_port (target_port),
		.motor_select(motor_select),
		.peak_speed  (peak_speed),
		.start_speed (start_speed),
		.ramp_percent(ramp_percent),
		.hold_ticks  (hold_ticks),
		.delay_ticks (delay_ticks),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_port    (out_port),
		.left_speed  (left_speed),
		.right_speed (right_speed),
		.last        (last),
		.drain_check (drain_check),
		.pending     (pending),
		.mismatches  (mismatches)
	);

	// receiver back-pressure
	always @(negedge clk)
		out_ready <= ($urandom_range(99) >= out_idle_pct);

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
				(psel && penable && pready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic send_txn(input logic [1:0] act, input logic [1:0] prt, input logic mot,
			input logic [15:0] pk, input logic [15:0] st, input logic [6:0] pct,
			input logic [15:0] hd, input logic [15:0] dl);
		while ($urandom_range(99) < in_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid     <= 1'b1;
		action       <= act;
		target_port  <= prt;
		motor_select <= mot;
		peak_speed   <= pk;
		start_speed  <= st;
		ramp_percent <= pct;
		hold_ticks   <= hd;
		delay_ticks  <= dl;
		do
			@(posedge clk);
		while (!(in_valid && in_ready));
		if (act != ACT_NONE)
			txn_count++;
		@(negedge clk);
	endtask

	task automatic send_tick();
		send_txn(ACT_TICK, 2'($urandom), 1'($urandom), 16'($urandom), 16'($urandom),
			7'($urandom), 16'($urandom), 16'($urandom));
	endtask

	task automatic send_clear();
		send_txn(ACT_CLEAR, 2'($urandom), 1'($urandom), 16'($urandom), 16'($urandom),
			7'($urandom), 16'($urandom), 16'($urandom));
	endtask

	// random envelope; fill mode keeps slots alive so the table stays full
	task automatic send_envelope(input bit fill_mode);
		logic [15:0] pk;
		logic [15:0] st;
		logic [6:0]  pct;
		logic [15:0] hd;
		logic [15:0] dl;
		pk  = ($urandom_range(1) != 0) ? 16'($urandom) : 16'($urandom_range(1, 300));
		case ($urandom_range(3))
			0, 1:    st = 16'd0;
			2:       st = 16'($urandom_range(0, 200));
			default: st = 16'($urandom);
		endcase
		pct = ($urandom_range(9) < 7) ? 7'($urandom_range(20, 100)) : 7'($urandom_range(0, 127));
		if (fill_mode)
			hd = 16'($urandom_range(200, 65535));
		else
			hd = ($urandom_range(9) < 8) ? 16'($urandom_range(0, 6)) : 16'($urandom);
		if (fill_mode || $urandom_range(9) < 8)
			dl = 16'($urandom_range(0, 4));
		else
			dl = 16'($urandom);
		send_txn(ACT_ADD, 2'($urandom), 1'($urandom), pk, st, pct, hd, dl);
	endtask

	task automatic cfg_write(input int idx, input logic val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= 3'(idx << 2);
		pwdata  <= {31'd0, val};
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
	endtask

	// hold the sender until every result is out, then let an add finish its walk
	task automatic drain_wait();
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	initial begin
		int seg_end;
		int pick;
		int n;
		bit first_seq;

		arst_n       = 1'b0;
		psel         = 1'b0;
		penable      = 1'b0;
		pwrite       = 1'b0;
		paddr        = 3'd0;
		pwdata       = 32'd0;
		in_valid     = 1'b0;
		action       = ACT_TICK;
		target_port  = 2'd0;
		motor_select = 1'b0;
		peak_speed   = 16'd0;
		start_speed  = 16'd0;
		ramp_percent = 7'd0;
		hold_ticks   = 16'd0;
		delay_ticks  = 16'd0;
		drain_check  = 1'b0;
		in_idle_pct  = 27;
		out_idle_pct = 71;
		txn_count    = 0;

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: empty table, extremes, saturated percent, zero step and hold
		send_tick();
		send_clear();
		send_txn(ACT_ADD, 2'd0, 1'b0, 16'hFFFF, 16'd0, 7'd100, 16'd0, 16'd0);
		send_txn(ACT_ADD, 2'd3, 1'b1, 16'd1000, 16'd0, 7'd127, 16'd1, 16'd2);
		send_txn(ACT_ADD, 2'd1, 1'b0, 16'd40000, 16'hFFFF, 7'd50, 16'd2, 16'd0);
		send_txn(ACT_ADD, 2'd2, 1'b1, 16'd500, 16'd0, 7'd0, 16'd3, 16'd0);
		send_txn(ACT_ADD, 2'd2, 1'b0, 16'd500, 16'd300, 7'd0, 16'd3, 16'd0);
		send_txn(ACT_ADD, 2'd1, 1'b1, 16'hFFFF, 16'hFFFF, 7'd1, 16'hFFFF, 16'hFFFF);
		send_txn(ACT_ADD, 2'd0, 1'b1, 16'd0, 16'd0, 7'd100, 16'd1, 16'd0);
		repeat (6) send_tick();
		send_txn(ACT_NONE, 2'd3, 1'b1, 16'hFFFF, 16'hFFFF, 7'h7F, 16'hFFFF, 16'hFFFF);
		send_txn(ACT_ADD, 2'd3, 1'b0, 16'd1, 16'd0, 7'd99, 16'd0, 16'd1);
		send_tick();
		send_tick();
		send_clear();
		send_tick();

		for (int seg = 0; seg < RAND_SEGMENTS; seg++) begin
			drain_wait();
			cfg_write(CFG_OUTPUT_ENABLE, OE_PLAN[seg]);
			cfg_write(CFG_DRIVE_ENABLE, DE_PLAN[seg]);
			case (seg / 2)
				0: begin
					in_idle_pct  = 27;
					out_idle_pct = 71;
				end
				1: begin
					in_idle_pct  = 71;
					out_idle_pct = 27;
				end
				default: begin
					in_idle_pct  = 0;
					out_idle_pct = 0;
				end
			endcase
			seg_end   = txn_count + RAND_PER_SEG;
			first_seq = 1;
			while (txn_count < seg_end) begin
				pick = $urandom_range(99);
				if (first_seq || pick < 7) begin
					// overfill the table, then run and clear it
					n = $urandom_range(17, 19);
					repeat (n) send_envelope(1'b1);
					n = $urandom_range(1, 3);
					repeat (n) send_tick();
					send_clear();
				end else if (pick < 22) begin
					n = $urandom_range(1, 4);
					repeat (n)
						send_txn(2'($urandom), 2'($urandom), 1'($urandom), 16'($urandom),
							16'($urandom), 7'($urandom), 16'($urandom), 16'($urandom));
				end else begin
					n = $urandom_range(1, 4);
					repeat (n) send_envelope(1'b0);
					n = $urandom_range(2, 12);
					repeat (n) send_tick();
				end
				if ($urandom_range(29) == 0)
					drain_wait();
				first_seq = 0;
			end
		end

		drain_wait();
		drain_check <= 1'b1;
		@(negedge clk);
		@(negedge clk);
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

FILE: filelist.f
hw/rtl/hem_pkg.sv
hw/rtl/hem_cell.sv
hw/rtl/hem_update.sv
hw/rtl/haptic_envelope_mixer.sv
dv/hem_checker.sv
dv/tb.sv
